// ===== rtl/core/lzb_pkg.sv =====
// ----------------------------------------------------------------------------
// lzb_pkg
// Shared types and constants for the LZ4 block decompressor.
// ----------------------------------------------------------------------------
package lzb_pkg;

  localparam int unsigned HIST_DEPTH = 65536;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // Operation codes carried in the input tuser.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // One input beat as it waits in the front queue.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // One decoded step handed from the parser to the copy stage.
  typedef struct packed {
    logic [7:0]         lit_byte;
    logic               use_hist;
    logic               bad;
    logic               emit;
    logic               block_end;
    logic               refused;
    logic [HIST_AW-1:0] raddr;
    logic [HIST_AW-1:0] waddr;
  } step_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       block_end;
    logic       refused;
    logic       bad;
  } out_item_t;

endpackage

// ===== rtl/core/lz4_block_decompressor_unit.sv =====
// ----------------------------------------------------------------------------
// lz4_block_decompressor_unit
// LZ4 block decompressor: one compressed byte or drain request per beat.
// ----------------------------------------------------------------------------
// Usage: compressed bytes enter on the s_axis channel with tuser = 0, tlast
// on the final byte of a block. A beat with tuser = 1 drains one pending
// match byte. Each compressed byte yields one result beat on m_axis; a drain
// yields one only while a copy is pending. A compressed byte sent while a
// copy is pending is answered with the refused flag and otherwise ignored.
// The output limit is written through cfg_we_i/cfg_wdata_i while idle.
// An accepted beat passes the queue entry, then the copy stage with the
// registered history read, then the output register before result valid.
// Throughput: one beat per cycle while m_axis_tready does not hold the
// output, set by the single read and single write port of the 64 KiB history.
// A two-entry input queue and the output register keep both sides moving;
// when m_axis_tready is low the result is held and the input side keeps
// taking beats until the queue is full. Reset empties the queue and the
// pipeline, returns the parser to expecting a token and sets the limit to
// all ones; the history needs no clearing.
// ----------------------------------------------------------------------------
module lz4_block_decompressor_unit
  import lzb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [0] out_valid, [1] refused, [2] bad_offset
  output logic        m_axis_tlast    // block_end
);

  in_item_t  push_item, q_item;
  logic      q_full, q_avail, take;
  logic      copy_ready, step_valid, out_free, res_valid;
  step_t     step;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_q;

  assign s_axis_tready = !q_full;
  assign push_item     = '{op: s_axis_tuser, data: s_axis_tdata, last: s_axis_tlast};
  assign take          = q_avail && copy_ready;
  assign out_free      = !out_valid_q || m_axis_tready;

  lzb_in_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid && !q_full),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (take),
    .avail_o    (q_avail),
    .pop_item_o (q_item)
  );

  lzb_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (q_item),
    .step_valid_o(step_valid),
    .step_o      (step)
  );

  lzb_copy u_copy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (take && step_valid),
    .step_i     (step),
    .ready_o    (copy_ready),
    .out_free_i (out_free),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = {out_q.bad, out_q.refused, out_q.valid};
  assign m_axis_tlast  = out_q.block_end;

endmodule

// ===== rtl/core/lzb_in_queue.sv =====
// ----------------------------------------------------------------------------
// lzb_in_queue
// Two-entry queue that decouples the input stream from the parser.
// ----------------------------------------------------------------------------
module lzb_in_queue
  import lzb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t push_item_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     avail_o,
  output in_item_t pop_item_o
);

  in_item_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = count_q == 2'd2;
  assign avail_o    = count_q != 2'd0;
  assign pop_item_o = mem_q[rd_ptr_q];

  // Storage for queued beats.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

// ===== rtl/core/lzb_parser.sv =====
// ----------------------------------------------------------------------------
// lzb_parser
// Parses LZ4 sequences; tracks lengths, offsets and history pointers; issues
// one step per accepted beat to the copy stage, none for a drain without copy.
// ----------------------------------------------------------------------------
module lzb_parser
  import lzb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        take_i,
  input  in_item_t    item_i,
  output logic        step_valid_o,
  output step_t       step_o
);

  localparam logic [2:0] PhToken    = 3'd0;
  localparam logic [2:0] PhLitExt   = 3'd1;
  localparam logic [2:0] PhLiteral  = 3'd2;
  localparam logic [2:0] PhOffLo    = 3'd3;
  localparam logic [2:0] PhOffHi    = 3'd4;
  localparam logic [2:0] PhMatchExt = 3'd5;

  logic [31:0]        max_len_q;
  logic [2:0]         phase_q, phase_d;
  logic [31:0]        lit_left_q, lit_left_d;
  logic [31:0]        match_left_q, match_left_d;
  logic [3:0]         nibble_q, nibble_d;
  logic [15:0]        offset_q, offset_d;
  logic [31:0]        produced_q, produced_d;
  logic [HIST_AW-1:0] wptr_q, wptr_d;
  logic               new_block_q, new_block_d;

  logic               pending;
  logic [31:0]        eff_produced;
  logic [HIST_AW-1:0] eff_wptr;
  logic               can_emit;
  logic [32:0]        lit_sum;
  logic [31:0]        lit_sat;
  logic [8:0]         match_inc;
  logic [32:0]        match_sum;
  logic [31:0]        match_sat;

  assign pending = (phase_q == PhToken) && (match_left_q != 32'd0);

  // A new block restarts the output count and history pointer.
  assign eff_produced = new_block_q ? 32'd0 : produced_q;
  assign eff_wptr     = new_block_q ? '0 : wptr_q;
  assign can_emit     = (item_i.op == OP_DRAIN) ? (produced_q < max_len_q)
                                                : (eff_produced < max_len_q);

  // Saturating length accumulators; a closing match byte also adds four.
  assign lit_sum   = {1'b0, lit_left_q} + {25'd0, item_i.data};
  assign lit_sat   = lit_sum[32] ? 32'hffff_ffff : lit_sum[31:0];
  assign match_inc = {1'b0, item_i.data} + ((item_i.data != 8'hff) ? 9'd4 : 9'd0);
  assign match_sum = {1'b0, match_left_q} + {24'd0, match_inc};
  assign match_sat = match_sum[32] ? 32'hffff_ffff : match_sum[31:0];

  // Next-state and step decode.
  always_comb begin
    phase_d      = phase_q;
    lit_left_d   = lit_left_q;
    match_left_d = match_left_q;
    nibble_d     = nibble_q;
    offset_d     = offset_q;
    produced_d   = produced_q;
    wptr_d       = wptr_q;
    new_block_d  = new_block_q;
    step_valid_o = 1'b0;
    step_o       = '0;
    step_o.raddr = wptr_q - offset_q[HIST_AW-1:0];
    step_o.waddr = wptr_q;

    if (item_i.op == OP_DRAIN) begin
      if (pending) begin
        step_valid_o    = 1'b1;
        step_o.bad      = (offset_q == 16'd0) || ({16'd0, offset_q} > produced_q);
        step_o.use_hist = !step_o.bad;
        step_o.emit     = can_emit;
        match_left_d    = match_left_q - 32'd1;
        if (can_emit) begin
          wptr_d     = wptr_q + 1'b1;
          produced_d = produced_q + 32'd1;
        end
      end
    end else if (pending) begin
      step_valid_o   = 1'b1;
      step_o.refused = 1'b1;
    end else begin
      step_valid_o = 1'b1;
      new_block_d  = 1'b0;
      produced_d   = eff_produced;
      wptr_d       = eff_wptr;
      step_o.waddr = eff_wptr;
      case (phase_q)
        PhToken: begin
          lit_left_d = {28'd0, item_i.data[7:4]};
          nibble_d   = item_i.data[3:0];
          if (item_i.data[7:4] == 4'hf)      phase_d = PhLitExt;
          else if (item_i.data[7:4] != 4'd0) phase_d = PhLiteral;
          else                               phase_d = PhOffLo;
        end
        PhLitExt: begin
          lit_left_d = lit_sat;
          if (item_i.data != 8'hff) begin
            phase_d = (lit_sat != 32'd0) ? PhLiteral : PhOffLo;
          end
        end
        PhLiteral: begin
          step_o.lit_byte = item_i.data;
          step_o.emit     = can_emit;
          if (can_emit) begin
            wptr_d     = eff_wptr + 1'b1;
            produced_d = eff_produced + 32'd1;
          end
          if (lit_left_q != 32'd0) lit_left_d = lit_left_q - 32'd1;
          if (lit_left_q <= 32'd1) phase_d = PhOffLo;
        end
        PhOffLo: begin
          offset_d = {8'd0, item_i.data};
          phase_d  = PhOffHi;
        end
        PhOffHi: begin
          offset_d = {item_i.data, offset_q[7:0]};
          if (nibble_q == 4'hf) begin
            match_left_d = 32'd15;
            phase_d      = PhMatchExt;
          end else begin
            match_left_d = {28'd0, nibble_q} + 32'd4;
            phase_d      = PhToken;
          end
        end
        default: begin
          match_left_d = match_sat;
          if (item_i.data != 8'hff) phase_d = PhToken;
        end
      endcase
      // The last byte closes the block and drops an unfinished sequence.
      if (item_i.last) begin
        step_o.block_end = 1'b1;
        new_block_d      = 1'b1;
        if (phase_d != PhToken) begin
          phase_d      = PhToken;
          match_left_d = 32'd0;
        end
        lit_left_d = 32'd0;
        nibble_d   = 4'd0;
      end
    end
  end

  // Parser state and the output limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= 32'hffff_ffff;
      phase_q      <= PhToken;
      lit_left_q   <= 32'd0;
      match_left_q <= 32'd0;
      nibble_q     <= 4'd0;
      offset_q     <= 16'd0;
      produced_q   <= 32'd0;
      wptr_q       <= '0;
      new_block_q  <= 1'b1;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      if (take_i) begin
        phase_q      <= phase_d;
        lit_left_q   <= lit_left_d;
        match_left_q <= match_left_d;
        nibble_q     <= nibble_d;
        offset_q     <= offset_d;
        produced_q   <= produced_d;
        wptr_q       <= wptr_d;
        new_block_q  <= new_block_d;
      end
    end
  end

endmodule

// ===== rtl/core/lzb_copy.sv =====
// ----------------------------------------------------------------------------
// lzb_copy
// History memory and copy stage: reads match bytes, forwards a byte written
// in the same cycle, stores emitted bytes and forms the result beat.
// ----------------------------------------------------------------------------
module lzb_copy
  import lzb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  step_t     step_i,
  output logic      ready_o,
  input  logic      out_free_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  logic [7:0] hist_mem [HIST_DEPTH];
  logic [7:0] rdata_q;
  logic       fwd_q;
  logic [7:0] fwd_data_q;
  logic       s2_valid_q;
  step_t      s2_q;
  logic       s2_adv;
  logic       wr_en;
  logic [7:0] s2_byte;

  assign s2_adv  = s2_valid_q && out_free_i;
  assign ready_o = !s2_valid_q || out_free_i;
  assign wr_en   = s2_adv && s2_q.emit;

  // Byte of the step in this stage: literal, history or zero on a bad offset.
  always_comb begin
    if (s2_q.bad)           s2_byte = 8'd0;
    else if (s2_q.use_hist) s2_byte = fwd_q ? fwd_data_q : rdata_q;
    else                    s2_byte = s2_q.lit_byte;
  end

  assign res_valid_o     = s2_valid_q;
  assign res_o.data      = s2_q.emit ? s2_byte : 8'd0;
  assign res_o.valid     = s2_q.emit;
  assign res_o.block_end = s2_q.block_end;
  assign res_o.refused   = s2_q.refused;
  assign res_o.bad       = s2_q.bad;

  // History memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[s2_q.waddr] <= s2_byte;
    end
    if (load_i) begin
      rdata_q <= hist_mem[step_i.raddr];
    end
  end

  // Step register and same-cycle write forwarding.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s2_q       <= step_i;
      fwd_data_q <= s2_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (load_i) begin
        s2_valid_q <= 1'b1;
        fwd_q      <= wr_en && (s2_q.waddr == step_i.raddr);
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // A bad offset never yields a nonzero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_q.bad |-> res_o.data == 8'd0)
    else $error("bad offset produced a nonzero byte");

  // A refused beat neither emits nor ends a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_q.refused |-> !s2_q.emit && !s2_q.block_end)
    else $error("refused beat carries data");

  // A held step keeps its byte while the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_free_i |=> s2_valid_q && $stable(s2_byte))
    else $error("stalled copy byte changed");

  // New steps load only when the stage can take them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("step loaded into a busy copy stage");

endmodule

// ===== tb/sv/lz4_block_decompressor_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz4_block_decompressor_unit_tb
// Self-checking bench for the LZ4 block decompressor. A behavioral decoder
// follows every accepted input beat and queues the result beat it expects.
// A scoreboard compares each output beat field by field. The bench runs
// directed blocks, then random well-formed blocks with drains and noise,
// under several output limits and with random gaps on both sides.
// ----------------------------------------------------------------------------
module lz4_block_decompressor_unit_tb;
  import lzb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITEXT, PH_LITERAL, PH_OFF_LO, PH_OFF_HI, PH_MATCHEXT
  } parse_phase_e;

  // Expected output beat.
  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       block_end;
    logic       refused;
    logic       bad;
  } lz_result_t;

  int unsigned error_count = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Decoder model and store of expected result beats.
  class lz_scoreboard;
    lz_result_t       pending_results[$];
    logic [31:0]      out_limit;
    parse_phase_e     phase;
    logic [31:0]      lit_left;
    logic [31:0]      copy_left;
    logic [3:0]       nibble;
    logic [15:0]      offset;
    logic [31:0]      produced;
    logic [7:0]       history [HIST_DEPTH];
    logic [15:0]      wr_ptr;
    bit               block_open;

    function new();
      out_limit  = '1;
      phase      = PH_TOKEN;
      lit_left   = 0;
      copy_left  = 0;
      nibble     = 0;
      offset     = 0;
      produced   = 0;
      wr_ptr     = 0;
      block_open = 1'b1;
    endfunction

    function bit copy_pending();
      return phase == PH_TOKEN && copy_left != 0;
    endfunction

    function logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    function bit store_byte(input logic [7:0] b);
      if (produced >= out_limit) return 1'b0;
      history[wr_ptr] = b;
      wr_ptr++;
      produced++;
      return 1'b1;
    endfunction

    // Notes one accepted input beat and queues the result it causes.
    function void note_input(input logic op, input logic [7:0] b, input logic last);
      lz_result_t r;
      logic [7:0] v;
      r = '{data: 8'h00, valid: 1'b0, block_end: 1'b0, refused: 1'b0, bad: 1'b0};
      if (op == OP_DRAIN) begin
        if (!copy_pending()) return;
        v = 8'h00;
        if (offset == 0 || offset > produced) r.bad = 1'b1;
        else v = history[wr_ptr - offset];
        if (store_byte(v)) begin
          r.data  = v;
          r.valid = 1'b1;
        end
        copy_left--;
      end else if (copy_pending()) begin
        r.refused = 1'b1;
      end else begin
        if (block_open) begin
          produced   = 0;
          wr_ptr     = 0;
          block_open = 1'b0;
        end
        case (phase)
          PH_TOKEN: begin
            lit_left = {28'd0, b[7:4]};
            nibble   = b[3:0];
            if (lit_left == 15) phase = PH_LITEXT;
            else phase = (lit_left != 0) ? PH_LITERAL : PH_OFF_LO;
          end
          PH_LITEXT: begin
            lit_left = add_sat(lit_left, {24'd0, b});
            if (b != 8'hff) phase = (lit_left != 0) ? PH_LITERAL : PH_OFF_LO;
          end
          PH_LITERAL: begin
            if (store_byte(b)) begin
              r.data  = b;
              r.valid = 1'b1;
            end
            if (lit_left != 0) lit_left--;
            if (lit_left == 0) phase = PH_OFF_LO;
          end
          PH_OFF_LO: begin
            offset = {8'h00, b};
            phase  = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            offset[15:8] = b;
            if (nibble == 4'hf) begin
              copy_left = 15;
              phase     = PH_MATCHEXT;
            end else begin
              copy_left = {28'd0, nibble} + 32'd4;
              phase     = PH_TOKEN;
            end
          end
          default: begin
            copy_left = add_sat(copy_left, {24'd0, b});
            if (b != 8'hff) begin
              copy_left = add_sat(copy_left, 32'd4);
              phase     = PH_TOKEN;
            end
          end
        endcase
        if (last) begin
          r.block_end = 1'b1;
          block_open  = 1'b1;
          if (phase != PH_TOKEN) begin
            phase     = PH_TOKEN;
            copy_left = 0;
          end
          lit_left = 0;
          nibble   = 0;
        end
      end
      pending_results.push_back(r);
    endfunction

    // Checks one output beat against the oldest expectation.
    task check_result(input logic [7:0] data, input logic [2:0] flags,
                      input logic tlast);
      lz_result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", data, 0);
        return;
      end
      e = pending_results.pop_front();
      if (flags[0] !== e.valid) report_mismatch("out_valid", flags[0], e.valid);
      if (flags[1] !== e.refused) report_mismatch("refused", flags[1], e.refused);
      if (flags[2] !== e.bad) report_mismatch("bad_offset", flags[2], e.bad);
      if (tlast !== e.block_end) report_mismatch("block_end", tlast, e.block_end);
      if (data !== e.data) report_mismatch("out_byte", data, e.data);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  lz_scoreboard sb = new();
  int unsigned  idle_cycles = 0;
  int unsigned  in_count = 0;
  bit           hold_sink = 1'b0;
  bit           sink_ready_mode = 1'b1;

  always #10 clk_i = ~clk_i;

  lz4_block_decompressor_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Accepted beats on both sides, plus the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        in_count++;
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("lz4_block_decompressor_unit verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, mostly short, sometimes long, sometimes none.
  initial begin : sink_proc
    int unsigned gap;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else if (sink_ready_mode || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end
      if ($urandom_range(0, 199) == 0) sink_ready_mode = ~sink_ready_mode;
    end
  end

  // Sends one beat and waits for it to be accepted, with a random gap first.
  // Returns only after the monitor has noted the beat.
  task automatic send_beat(input logic op, input logic [7:0] b, input logic last,
                           input bit gaps = 1'b1);
    int unsigned gap;
    int unsigned want;
    want = in_count + 1;
    if (gaps && $urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 2);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    wait (in_count == want);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last = 1'b0);
    send_beat(OP_BYTE, b, last);
  endtask

  // Drains a pending copy completely.
  task automatic drain_all();
    while (sb.copy_pending())
      send_beat(OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Waits until all results have arrived, then for the pipeline to settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.out_limit = v;
  endtask

  // Sends one sequence with extension bytes when needed, then drains the copy.
  task automatic send_sequence(input int unsigned nlit, input int unsigned mlen,
                               input logic [15:0] off, input bit fin);
    int unsigned rest;
    logic [3:0]  lnib;
    logic [3:0]  mnib;
    lnib = (nlit >= 15) ? 4'hf : nlit[3:0];
    mnib = (mlen >= 19) ? 4'hf : 4'(mlen - 4);
    send_byte({lnib, mnib});
    if (lnib == 4'hf) begin
      rest = nlit - 15;
      while (rest >= 255) begin send_byte(8'hff); rest -= 255; end
      send_byte(rest[7:0]);
    end
    for (int i = 0; i < nlit; i++)
      send_byte(8'($urandom_range(0, 255)), fin && i == nlit - 1 && mlen < 4);
    if (mlen < 4) return;
    send_byte(off[7:0]);
    send_byte(off[15:8], fin && mnib != 4'hf);
    if (mnib == 4'hf) begin
      rest = mlen - 19;
      while (rest >= 255) begin send_byte(8'hff); rest -= 255; end
      send_byte(rest[7:0], fin);
    end
    drain_all();
  endtask

  // Random well-formed block; offsets mostly legal.
  task automatic send_random_block();
    int unsigned nseq;
    int unsigned nlit;
    int unsigned mlen;
    logic [15:0] off;
    nseq = $urandom_range(1, 4);
    for (int s = 0; s < nseq; s++) begin
      nlit = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 8);
      if (s == 0 && nlit == 0) nlit = 1;
      mlen = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 30) : $urandom_range(4, 10);
      if ($urandom_range(0, 4) == 0 && s == nseq - 1) mlen = 0;
      off = 16'($urandom_range(1, sb.produced + nlit));
      if ($urandom_range(0, 15) == 0) off = ($urandom_range(0, 1) != 0) ? 16'h0 : 16'hffff;
      send_sequence(nlit, mlen, off, s == nseq - 1);
    end
  endtask

  initial begin : stim
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: drain with nothing pending, refused byte, overlapping copy.
    send_beat(OP_DRAIN, 8'h00, 1'b0);
    send_sequence(2, 6, 16'd1, 1'b0);
    send_byte(8'h10);
    send_byte(8'hab);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h55);                 // refused while copy is pending
    drain_all();
    send_sequence(1, 5, 16'd0, 1'b0); // zero offset
    send_sequence(1, 4, 16'hffff, 1'b0);
    send_sequence(15, 19, 16'd3, 1'b1);
    send_byte(8'hf0);                 // literal extension 0xff then 0
    send_byte(8'hff);
    send_byte(8'h00, 1'b1);           // truncated block
    send_byte(8'h0f);                 // zero literals
    send_byte(8'h00);
    send_byte(8'h00, 1'b1);           // match length unfinished at last byte

    // Pressure: hold the receiver until the input stalls.
    hold_sink = 1'b1;
    fork
      begin repeat (60) @(posedge clk_i); hold_sink = 1'b0; end
      begin
        for (int i = 0; i < 12; i++)
          send_beat(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        for (int i = 0; i < 6; i++) send_beat(OP_BYTE, 8'h00, i == 5, 1'b0);
      end
    join
    drain_all();
    wait_idle();

    // Random phases over several output limits.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_limit(32'h0);
        1: write_limit(32'd5);
        2: write_limit($urandom_range(1, 40));
        3: write_limit(32'hffff_ffff);
        default: write_limit(32'h7fff_ffff);
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        send_random_block();
        if ($urandom_range(0, 3) == 0) begin
          send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
          drain_all();
        end
      end
    end

    // Long literal run whose length saturates nothing but spans extensions.
    send_sequence(300, 20, 16'd200, 1'b1);
    wait_idle();
    if (error_count == 0) begin
      $display("lz4_block_decompressor_unit verification clean");
    end else begin
      $display("lz4_block_decompressor_unit verification failed");
    end
    $finish;
  end

endmodule
